// File: design/spi_nor_flash_command_sequencer_core_assert.svh
// assertion macros used by the sequencer back end
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_ASSERT_SVH

// check a property on the rising clock edge outside reset
`define SNF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define SNF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// File: design/snf_pkg.sv
// package: types, constants and opcodes of the spi nor flash sequencer
package snf_pkg;

    localparam int PageSize    = 256;
    localparam int SectorSize  = 4096;
    localparam int AddrBits    = 24;
    localparam int AddrBytes   = (AddrBits + 7) / 8;
    localparam int SecBits     = $clog2(SectorSize);
    localparam int PageBits    = $clog2(PageSize);
    localparam int HdrBits     = $clog2(AddrBytes + 1) + 1;

    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_PP   = 8'h02;
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_WRSR = 8'h01;
    localparam logic [7:0] OP_SE   = 8'h20;
    localparam logic [7:0] OP_CE   = 8'hC7;
    localparam logic [7:0] OP_ID   = 8'h90;
    localparam logic [7:0] OP_PD   = 8'hB9;
    localparam logic [7:0] OP_WAKE = 8'hAB;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_00 = 8'h00;

    localparam logic [3:0] REQ_READ   = 4'd0;
    localparam logic [3:0] REQ_WRITE  = 4'd1;
    localparam logic [3:0] REQ_ERASE  = 4'd2;
    localparam logic [3:0] REQ_CHIP   = 4'd3;
    localparam logic [3:0] REQ_RDSR   = 4'd4;
    localparam logic [3:0] REQ_WRSR   = 4'd5;
    localparam logic [3:0] REQ_WREN   = 4'd6;
    localparam logic [3:0] REQ_WRDI   = 4'd7;
    localparam logic [3:0] REQ_ID     = 4'd8;
    localparam logic [3:0] REQ_PD     = 4'd9;
    localparam logic [3:0] REQ_WAKE   = 4'd10;
    localparam logic [3:0] REQ_DATA   = 4'd11;
    localparam logic [3:0] REQ_RX     = 4'd12;

    localparam logic [2:0] KIND_SPI   = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_STAT  = 3'd2;
    localparam logic [2:0] KIND_ID    = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_DREQ  = 3'd5;
    localparam logic [2:0] KIND_ERR   = 3'd6;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  spi_byte;
        logic        release_select;
        logic [15:0] value;
        logic [12:0] data_count;
        logic        last;
    } out_item_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ONE, PH_WRSR, PH_STAT_A, PH_STAT_B, PH_ID,
        PH_RD_HDR, PH_RD_DATA, PH_W_HDR, PH_W_FILL, PH_W_DATA,
        PH_E_WREN, PH_E_P1A, PH_E_P1B, PH_E_HDR, PH_E_P2A, PH_E_P2B,
        PH_P_WREN, PH_P_HDR, PH_P_DATA, PH_P_PA, PH_P_PB
    } phase_t;

    typedef enum logic [1:0] {
        CL_HOST, CL_DATA, CL_RX, CL_ERR
    } class_t;

    // classified request between front and back
    typedef struct packed {
        class_t   cls;
        in_item_t item;
    } cmd_t;

    // result of one step: up to three result items
    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
        out_item_t  r2;
    } bundle_t;

    function automatic out_item_t mk(input logic [2:0] k, input logic [7:0] b,
                                     input logic rel, input logic [15:0] v,
                                     input logic [12:0] c);
        out_item_t o;
        o.kind = k;
        o.spi_byte = b;
        o.release_select = rel;
        o.value = v;
        o.data_count = c;
        o.last = 1'b0;
        return o;
    endfunction

endpackage

// File: design/spi_nor_flash_command_sequencer_core.sv
// top level of the spi nor flash command sequencer
//
// channel  | valid     | stall     | payload
// request  | in_valid  | in_stall  | in_data  (in_item_t)
// result   | out_valid | out_stall | out_data (out_item_t)
//
// one request is taken per cycle into a two-entry queue while the queue is not full; the back end
// retires one queued request per cycle while its result fifo has room
// for three results, so a request with one result sustains one per cycle
// and a request with two results holds the back end until the fifo has that room again
// reset clears the phase, the sequencer counters and both queues; the
// sector store holds no reset and is always filled by a sector read before use
// a stall on the result side backs up the result fifo, then the queue
module spi_nor_flash_command_sequencer_core import snf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    // queue between classifier and sequencer
    logic q_valid;
    logic q_take;
    cmd_t q_data;

    // front end classifies each request as host command, data, spi rx or error
    snf_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
    );

    // back end runs the command phases and owns the sector store
    snf_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

// File: design/snf_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
module snf_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/snf_front.sv
// front end: accepts requests, classifies them and queues them
module snf_front import snf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_take,
    output cmd_t     q_data
);
    localparam int QDepth = 2;

    cmd_t       buf_reg [QDepth];
    logic [0:0] rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd;
    logic       push, pop;

    always_comb
    begin
        cmd.item = in_data;
        if (in_data.req_type == REQ_DATA)
        begin
            cmd.cls = CL_DATA;
        end
        else if (in_data.req_type == REQ_RX)
        begin
            cmd.cls = CL_RX;
        end
        else if (in_data.req_type > REQ_RX)
        begin
            cmd.cls = CL_ERR;
        end
        else
        begin
            cmd.cls = CL_HOST;
        end
    end

    assign in_stall = (cnt_reg == 2'(QDepth));
    assign push = in_valid && !in_stall;
    assign pop = q_valid && q_take;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: design/snf_back.sv
// back end: sequencer state machine, sector store and result fifo
module snf_back import snf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_take,
    input  cmd_t      q_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    `include "spi_nor_flash_command_sequencer_core_assert.svh"

    localparam int SecCnt = SecBits + 1;

    phase_t              phase_reg, phase_next;
    logic [AddrBits-1:0] addr_reg, addr_next;
    logic [15:0]         total_reg, total_next;
    logic [SecBits-1:0]  soff_reg, soff_next;
    logic [SecCnt-1:0]   sleft_reg, sleft_next;
    logic [PageBits:0]   pleft_reg, pleft_next;
    logic [SecCnt-1:0]   bidx_reg, bidx_next;
    logic                erase_reg, erase_next;
    logic [7:0]          idhi_reg, idhi_next;
    logic [HdrBits-1:0]  hdr_reg, hdr_next;
    logic [7:0]          op_reg, op_next;

    // program pipeline: the store read is registered, so the data byte is prefetched
    logic                ram_we;
    logic [SecBits-1:0]  ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    bundle_t             b;
    logic                step;

    // output fifo of result items
    localparam int OD = 4;
    out_item_t  of_reg [OD];
    logic [1:0] ofr_reg, ofw_reg;
    logic [2:0] ofc_reg;

    snf_ram #(.Width(8), .Depth(SectorSize)) u_store (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // room for a full step of three results
    assign step = q_valid && (ofc_reg <= 3'(OD - 3));
    assign q_take = step;

    function automatic logic [7:0] addr_byte(input logic [AddrBits-1:0] a,
                                             input logic [HdrBits-1:0] pos);
        logic [AddrBytes*8-1:0] w;
        w = (AddrBytes*8)'(a);
        return w[(AddrBytes - 1 - int'(pos)) * 8 +: 8];
    endfunction

    logic [AddrBits-1:0] sbase;
    logic [SecCnt-1:0]   pend;
    logic [AddrBits-1:0] paddr;
    logic [PageBits:0]   proom;
    logic [SecCnt-1:0]   prest;
    logic [SecCnt-1:0]   proom_w;
    logic [SecCnt-1:0]   room;
    logic [SecCnt-1:0]   widx;
    logic [7:0]          rx;
    in_item_t            it;

    assign sbase = {addr_reg[AddrBits-1:SecBits], {SecBits{1'b0}}};
    assign it = q_data.item;
    assign rx = it.data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        addr_next = addr_reg;
        total_next = total_reg;
        soff_next = soff_reg;
        sleft_next = sleft_reg;
        pleft_next = pleft_reg;
        bidx_next = bidx_reg;
        erase_next = erase_reg;
        idhi_next = idhi_reg;
        hdr_next = hdr_reg;
        op_next = op_reg;
        b = '0;
        ram_we = 1'b0;
        ram_waddr = bidx_reg[SecBits-1:0];
        ram_wdata = rx;
        ram_raddr = bidx_reg[SecBits-1:0];
        pend = erase_reg ? SecCnt'(SectorSize) : SecCnt'({1'b0, soff_reg} + sleft_reg);
        paddr = '0;
        proom = '0;
        prest = '0;
        proom_w = '0;
        room = '0;
        widx = '0;
        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                b.count = 2'd1;
                case (it.req_type)
                    REQ_READ:
                    begin
                        addr_next = it.address[AddrBits-1:0];
                        total_next = it.length;
                        hdr_next = '0;
                        b.r0 = mk(KIND_SPI, OP_READ, 1'b0, '0, '0);
                        phase_next = PH_RD_HDR;
                    end
                    REQ_WRITE:
                    begin
                        if (it.length == 16'd0)
                        begin
                            b.r0 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                        end
                        else
                        begin
                            addr_next = it.address[AddrBits-1:0];
                            total_next = it.length;
                            soff_next = it.address[SecBits-1:0];
                            room = SecCnt'(SectorSize) - SecCnt'(it.address[SecBits-1:0]);
                            sleft_next = ({1'b0, it.length} < 17'(room))
                                ? SecCnt'(it.length) : room;
                            erase_next = 1'b0;
                            hdr_next = '0;
                            b.r0 = mk(KIND_SPI, OP_READ, 1'b0, '0, '0);
                            phase_next = PH_W_HDR;
                        end
                    end
                    REQ_ERASE:
                    begin
                        addr_next = {it.address[AddrBits-SecBits-1:0], {SecBits{1'b0}}};
                        erase_next = 1'b0;
                        op_next = OP_SE;
                        b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                        phase_next = PH_E_WREN;
                    end
                    REQ_CHIP:
                    begin
                        erase_next = 1'b0;
                        op_next = OP_CE;
                        b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                        phase_next = PH_E_WREN;
                    end
                    REQ_RDSR:
                    begin
                        b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                        phase_next = PH_STAT_A;
                    end
                    REQ_WRSR:
                    begin
                        op_next = it.data_byte;
                        b.r0 = mk(KIND_SPI, OP_WRSR, 1'b0, '0, '0);
                        phase_next = PH_WRSR;
                    end
                    REQ_WREN:
                    begin
                        b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                        phase_next = PH_ONE;
                    end
                    REQ_WRDI:
                    begin
                        b.r0 = mk(KIND_SPI, OP_WRDI, 1'b1, '0, '0);
                        phase_next = PH_ONE;
                    end
                    REQ_ID:
                    begin
                        hdr_next = '0;
                        b.r0 = mk(KIND_SPI, OP_ID, 1'b0, '0, '0);
                        phase_next = PH_ID;
                    end
                    REQ_PD:
                    begin
                        b.r0 = mk(KIND_SPI, OP_PD, 1'b1, '0, '0);
                        phase_next = PH_ONE;
                    end
                    REQ_WAKE:
                    begin
                        b.r0 = mk(KIND_SPI, OP_WAKE, 1'b1, '0, '0);
                        phase_next = PH_ONE;
                    end
                    default:
                    begin
                        b.r0 = mk(KIND_ERR, '0, 1'b0, '0, '0);
                    end
                endcase
            end
            else if (phase_reg == PH_W_DATA)
            begin
                if (q_data.cls != CL_DATA)
                begin
                    b.count = 2'd1;
                    b.r0 = mk(KIND_ERR, '0, 1'b0, '0, '0);
                end
                else
                begin
                    widx = SecCnt'({1'b0, soff_reg} + bidx_reg);
                    ram_we = !widx[SecBits];
                    ram_waddr = widx[SecBits-1:0];
                    bidx_next = bidx_reg + 1'b1;
                    if (bidx_next >= sleft_reg)
                    begin
                        b.count = 2'd1;
                        if (erase_reg)
                        begin
                            op_next = OP_SE;
                            b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                            phase_next = PH_E_WREN;
                        end
                        else
                        begin
                            bidx_next = SecCnt'(soff_reg);
                            b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                            phase_next = PH_P_WREN;
                        end
                    end
                end
            end
            else if (q_data.cls != CL_RX)
            begin
                b.count = 2'd1;
                b.r0 = mk(KIND_ERR, '0, 1'b0, '0, '0);
            end
            else
            begin
                b.count = 2'd1;
                case (phase_reg)
                    PH_ONE:
                    begin
                        b.r0 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                        phase_next = PH_IDLE;
                    end
                    PH_WRSR:
                    begin
                        b.r0 = mk(KIND_SPI, op_reg, 1'b1, '0, '0);
                        phase_next = PH_ONE;
                    end
                    PH_STAT_A:
                    begin
                        b.r0 = mk(KIND_SPI, BYTE_FF, 1'b1, '0, '0);
                        phase_next = PH_STAT_B;
                    end
                    PH_STAT_B:
                    begin
                        b.count = 2'd2;
                        b.r0 = mk(KIND_STAT, '0, 1'b0, {8'h00, rx}, '0);
                        b.r1 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                        phase_next = PH_IDLE;
                    end
                    PH_ID:
                    begin
                        if (hdr_reg < HdrBits'(3))
                        begin
                            hdr_next = hdr_reg + 1'b1;
                            b.r0 = mk(KIND_SPI, BYTE_00, 1'b0, '0, '0);
                        end
                        else if (hdr_reg == HdrBits'(3))
                        begin
                            hdr_next = HdrBits'(4);
                            b.r0 = mk(KIND_SPI, BYTE_FF, 1'b0, '0, '0);
                        end
                        else if (hdr_reg == HdrBits'(4))
                        begin
                            idhi_next = rx;
                            hdr_next = HdrBits'(5);
                            b.r0 = mk(KIND_SPI, BYTE_FF, 1'b1, '0, '0);
                        end
                        else
                        begin
                            b.count = 2'd2;
                            b.r0 = mk(KIND_ID, '0, 1'b0, {idhi_reg, rx}, '0);
                            b.r1 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RD_HDR:
                    begin
                        if (hdr_reg < HdrBits'(AddrBytes))
                        begin
                            hdr_next = hdr_reg + 1'b1;
                            b.r0 = mk(KIND_SPI, addr_byte(addr_reg, hdr_reg),
                                      (total_reg == 16'd0) && (hdr_next == HdrBits'(AddrBytes)),
                                      '0, '0);
                        end
                        else if (total_reg == 16'd0)
                        begin
                            b.r0 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            b.r0 = mk(KIND_SPI, BYTE_FF, total_reg == 16'd1, '0, '0);
                            phase_next = PH_RD_DATA;
                        end
                    end
                    PH_RD_DATA:
                    begin
                        b.count = 2'd2;
                        b.r0 = mk(KIND_READ, '0, 1'b0, {8'h00, rx}, '0);
                        total_next = total_reg - 1'b1;
                        if (total_next == 16'd0)
                        begin
                            b.r1 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            b.r1 = mk(KIND_SPI, BYTE_FF, total_next == 16'd1, '0, '0);
                        end
                    end
                    PH_W_HDR:
                    begin
                        if (hdr_reg < HdrBits'(AddrBytes))
                        begin
                            hdr_next = hdr_reg + 1'b1;
                            b.r0 = mk(KIND_SPI, addr_byte(sbase, hdr_reg), 1'b0, '0, '0);
                        end
                        else
                        begin
                            bidx_next = '0;
                            b.r0 = mk(KIND_SPI, BYTE_FF, SectorSize == 1, '0, '0);
                            phase_next = PH_W_FILL;
                        end
                    end
                    PH_W_FILL:
                    begin
                        ram_we = 1'b1;
                        if (bidx_reg >= SecCnt'(soff_reg) && bidx_reg < pend
                            && rx != BYTE_FF)
                        begin
                            erase_next = 1'b1;
                        end
                        bidx_next = bidx_reg + 1'b1;
                        if (bidx_next < SecCnt'(SectorSize))
                        begin
                            b.r0 = mk(KIND_SPI, BYTE_FF,
                                      bidx_next == SecCnt'(SectorSize - 1), '0, '0);
                        end
                        else
                        begin
                            b.r0 = mk(KIND_DREQ, '0, 1'b0, '0, 13'(sleft_reg));
                            bidx_next = '0;
                            phase_next = PH_W_DATA;
                        end
                    end
                    PH_E_WREN:
                    begin
                        b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                        phase_next = PH_E_P1A;
                    end
                    PH_E_P1A:
                    begin
                        b.r0 = mk(KIND_SPI, BYTE_FF, 1'b1, '0, '0);
                        phase_next = PH_E_P1B;
                    end
                    PH_E_P2A:
                    begin
                        b.r0 = mk(KIND_SPI, BYTE_FF, 1'b1, '0, '0);
                        phase_next = PH_E_P2B;
                    end
                    PH_P_PA:
                    begin
                        b.r0 = mk(KIND_SPI, BYTE_FF, 1'b1, '0, '0);
                        phase_next = PH_P_PB;
                    end
                    PH_E_P1B:
                    begin
                        if (rx[0])
                        begin
                            b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                            phase_next = PH_E_P1A;
                        end
                        else
                        begin
                            b.r0 = mk(KIND_SPI, op_reg, op_reg == OP_CE, '0, '0);
                            hdr_next = (op_reg == OP_CE) ? HdrBits'(AddrBytes) : '0;
                            phase_next = PH_E_HDR;
                        end
                    end
                    PH_E_HDR:
                    begin
                        if (hdr_reg < HdrBits'(AddrBytes))
                        begin
                            hdr_next = hdr_reg + 1'b1;
                            b.r0 = mk(KIND_SPI, addr_byte(sbase, hdr_reg),
                                      hdr_next == HdrBits'(AddrBytes), '0, '0);
                        end
                        else
                        begin
                            b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                            phase_next = PH_E_P2A;
                        end
                    end
                    PH_E_P2B:
                    begin
                        if (rx[0])
                        begin
                            b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                            phase_next = PH_E_P2A;
                        end
                        else if (erase_reg)
                        begin
                            bidx_next = '0;
                            b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                            phase_next = PH_P_WREN;
                        end
                        else
                        begin
                            b.r0 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_P_WREN:
                    begin
                        // page length worked out here from byte index
                        paddr = sbase + AddrBits'(bidx_reg);
                        proom = (PageBits+1)'(PageSize) - (PageBits+1)'(paddr[PageBits-1:0]);
                        prest = pend - bidx_reg;
                        proom_w = SecCnt'(proom);
                        pleft_next = (prest < proom_w) ? (PageBits+1)'(prest) : proom;
                        hdr_next = '0;
                        b.r0 = mk(KIND_SPI, OP_PP, 1'b0, '0, '0);
                        phase_next = PH_P_HDR;
                    end
                    PH_P_HDR:
                    begin
                        paddr = sbase + AddrBits'(bidx_reg);
                        hdr_next = hdr_reg + 1'b1;
                        b.r0 = mk(KIND_SPI, addr_byte(paddr, hdr_reg), 1'b0, '0, '0);
                        if (hdr_next >= HdrBits'(AddrBytes))
                        begin
                            phase_next = PH_P_DATA;
                        end
                    end
                    PH_P_DATA:
                    begin
                        if (pleft_reg == '0)
                        begin
                            b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                            phase_next = PH_P_PA;
                        end
                        else
                        begin
                            b.r0 = mk(KIND_SPI, ram_rdata, pleft_reg == (PageBits+1)'(1),
                                      '0, '0);
                            bidx_next = bidx_reg + 1'b1;
                            pleft_next = pleft_reg - 1'b1;
                        end
                    end
                    PH_P_PB:
                    begin
                        if (rx[0])
                        begin
                            b.r0 = mk(KIND_SPI, OP_RDSR, 1'b0, '0, '0);
                            phase_next = PH_P_PA;
                        end
                        else if (bidx_reg < pend)
                        begin
                            b.r0 = mk(KIND_SPI, OP_WREN, 1'b1, '0, '0);
                            phase_next = PH_P_WREN;
                        end
                        else
                        begin
                            addr_next = addr_reg + AddrBits'(sleft_reg);
                            total_next = ({1'b0, total_reg} > 17'(sleft_reg))
                                ? total_reg - 16'(sleft_reg) : 16'd0;
                            if (total_next == 16'd0)
                            begin
                                b.r0 = mk(KIND_DONE, '0, 1'b0, '0, '0);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                soff_next = addr_next[SecBits-1:0];
                                room = SecCnt'(SectorSize) - SecCnt'(addr_next[SecBits-1:0]);
                                sleft_next = ({1'b0, total_next} < 17'(room))
                                    ? SecCnt'(total_next) : room;
                                erase_next = 1'b0;
                                hdr_next = '0;
                                b.r0 = mk(KIND_SPI, OP_READ, 1'b0, '0, '0);
                                phase_next = PH_W_HDR;
                            end
                        end
                    end
                    default:
                    begin
                        b.r0 = mk(KIND_ERR, '0, 1'b0, '0, '0);
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            case (b.count)
                2'd1: b.r0.last = 1'b1;
                2'd2: b.r1.last = 1'b1;
                2'd3: b.r2.last = 1'b1;
                default: b.r0.last = 1'b0;
            endcase
        end
        // keep the store read ahead of the program data phase
        ram_raddr = bidx_next[SecBits-1:0];
    end

    assign out_valid = (ofc_reg != 3'd0);
    assign out_data = of_reg[ofr_reg];

    logic pop;
    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (b.count != 2'd0)
        begin
            of_reg[ofw_reg] <= b.r0;
        end
        if (b.count >= 2'd2)
        begin
            of_reg[ofw_reg + 2'd1] <= b.r1;
        end
        if (b.count == 2'd3)
        begin
            of_reg[ofw_reg + 2'd2] <= b.r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ofr_reg <= '0;
            ofw_reg <= '0;
            ofc_reg <= '0;
            soff_reg <= '0;
            sleft_reg <= '0;
            pleft_reg <= '0;
            bidx_reg <= '0;
            idhi_reg <= '0;
            op_reg <= '0;
            addr_reg <= '0;
            total_reg <= '0;
            erase_reg <= 1'b0;
            hdr_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ofw_reg <= ofw_reg + b.count;
            ofr_reg <= ofr_reg + 2'(pop);
            ofc_reg <= ofc_reg + 3'(b.count) - 3'(pop);
            soff_reg <= soff_next;
            sleft_reg <= sleft_next;
            pleft_reg <= pleft_next;
            bidx_reg <= bidx_next;
            idhi_reg <= idhi_next;
            op_reg <= op_next;
            addr_reg <= addr_next;
            total_reg <= total_next;
            erase_reg <= erase_next;
            hdr_reg <= hdr_next;
        end
    end

    `SNF_ASSERT(a_fifo_bound, ofc_reg <= 3'(OD), "result fifo overflow")
    `SNF_ASSERT(a_step_result, !step || phase_reg == PH_W_DATA || b.count != 2'd0,
        "step outside data phase produced no result")
    `SNF_ASSERT_NEXT(a_no_take_full, ofc_reg > 3'(OD - 3), !$past(q_take),
        "request taken without room for its results")
endmodule

// File: tb/tb_spi_nor_flash_command_sequencer_core.sv
// testbench of the spi nor flash command sequencer: predicted results against the block
module tb_spi_nor_flash_command_sequencer_core;
    import snf_pkg::*;

    // run is cut off here; the slowest correct run needs far fewer cycles
    localparam int CycleLimit = 3000000;
    localparam logic [23:0] AddrMask = 24'hFFFFFF;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    spi_nor_flash_command_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // results still owed by the block, oldest first
    out_item_t owed_results[$];
    out_item_t step_results[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        no_idling = 0;
    bit        dirty_fill = 0;

    // predicted flash sequencer state
    phase_t      ph;
    logic [23:0] cur_addr;
    int unsigned total_left;
    int unsigned sec_off;
    int unsigned sec_left;
    int unsigned page_left;
    int unsigned bidx;
    bit          need_erase;
    logic [15:0] id_word;
    int unsigned hpos;
    logic [7:0]  pend_op;
    logic [7:0]  sec_copy [SectorSize];

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side stall
    always @(posedge clk)
    begin
        if (no_idling)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 12);
    end

    // ---------------- predictor ----------------

    function automatic void put(logic [2:0] k, logic [7:0] b, logic rel, logic [15:0] v,
                                logic [12:0] c);
        out_item_t o;
        o.kind = k;
        o.spi_byte = b;
        o.release_select = rel;
        o.value = v;
        o.data_count = c;
        o.last = 1'b0;
        step_results.push_back(o);
    endfunction

    function automatic void spi(logic [7:0] b, logic rel);
        put(KIND_SPI, b, rel, 16'd0, 13'd0);
    endfunction

    function automatic void done_op();
        put(KIND_DONE, 8'd0, 1'b0, 16'd0, 13'd0);
        ph = PH_IDLE;
    endfunction

    function automatic logic [23:0] sec_base();
        return cur_addr - (cur_addr % SectorSize);
    endfunction

    function automatic void hdr_next(logic [23:0] a, bit rel_end);
        int unsigned sh;
        hpos++;
        sh = 8 * (AddrBytes - hpos);
        spi(8'((a & AddrMask) >> sh), rel_end && hpos == AddrBytes);
    endfunction

    function automatic void start_sector();
        int unsigned room;
        sec_off = cur_addr % SectorSize;
        room = SectorSize - sec_off;
        sec_left = (total_left < room) ? total_left : room;
        need_erase = 0;
        hpos = 0;
        spi(OP_READ, 1'b0);
        ph = PH_W_HDR;
    endfunction

    function automatic int unsigned prog_end();
        return need_erase ? SectorSize : sec_off + sec_left;
    endfunction

    function automatic void start_page();
        logic [23:0] a;
        int unsigned room;
        int unsigned rest;
        a = (sec_base() + bidx) & AddrMask;
        room = PageSize - (a % PageSize);
        rest = prog_end() - bidx;
        page_left = (rest < room) ? rest : room;
        spi(OP_WREN, 1'b1);
        ph = PH_P_WREN;
    endfunction

    function automatic void start_program();
        bidx = need_erase ? 0 : sec_off;
        start_page();
    endfunction

    function automatic void start_erase(logic [7:0] op);
        pend_op = op;
        spi(OP_WREN, 1'b1);
        ph = PH_E_WREN;
    endfunction

    function automatic void host_cmd(in_item_t it);
        case (it.req_type)
            REQ_READ:
            begin
                cur_addr = it.address;
                total_left = it.length;
                hpos = 0;
                spi(OP_READ, 1'b0);
                ph = PH_RD_HDR;
            end
            REQ_WRITE:
            begin
                if (it.length == 0)
                    done_op();
                else
                begin
                    cur_addr = it.address;
                    total_left = it.length;
                    start_sector();
                end
            end
            REQ_ERASE:
            begin
                cur_addr = {it.address[11:0], 12'd0};
                need_erase = 0;
                start_erase(OP_SE);
            end
            REQ_CHIP:
            begin
                need_erase = 0;
                start_erase(OP_CE);
            end
            REQ_RDSR:
            begin
                spi(OP_RDSR, 1'b0);
                ph = PH_STAT_A;
            end
            REQ_WRSR:
            begin
                pend_op = it.data_byte;
                spi(OP_WRSR, 1'b0);
                ph = PH_WRSR;
            end
            REQ_WREN:
            begin
                spi(OP_WREN, 1'b1);
                ph = PH_ONE;
            end
            REQ_WRDI:
            begin
                spi(OP_WRDI, 1'b1);
                ph = PH_ONE;
            end
            REQ_ID:
            begin
                hpos = 0;
                spi(OP_ID, 1'b0);
                ph = PH_ID;
            end
            REQ_PD:
            begin
                spi(OP_PD, 1'b1);
                ph = PH_ONE;
            end
            REQ_WAKE:
            begin
                spi(OP_WAKE, 1'b1);
                ph = PH_ONE;
            end
            default: put(KIND_ERR, 8'd0, 1'b0, 16'd0, 13'd0);
        endcase
    endfunction

    // one returned spi byte moves the sequence on by one step
    function automatic void spi_return(logic [7:0] rx);
        case (ph)
            PH_ONE: done_op();
            PH_WRSR:
            begin
                spi(pend_op, 1'b1);
                ph = PH_ONE;
            end
            PH_STAT_A:
            begin
                spi(BYTE_FF, 1'b1);
                ph = PH_STAT_B;
            end
            PH_STAT_B:
            begin
                put(KIND_STAT, 8'd0, 1'b0, {8'd0, rx}, 13'd0);
                done_op();
            end
            PH_ID:
            begin
                if (hpos < 3)
                begin
                    hpos++;
                    spi(BYTE_00, 1'b0);
                end
                else if (hpos == 3)
                begin
                    hpos = 4;
                    spi(BYTE_FF, 1'b0);
                end
                else if (hpos == 4)
                begin
                    id_word = {rx, 8'd0};
                    hpos = 5;
                    spi(BYTE_FF, 1'b1);
                end
                else
                begin
                    id_word = id_word | {8'd0, rx};
                    put(KIND_ID, 8'd0, 1'b0, id_word, 13'd0);
                    done_op();
                end
            end
            PH_RD_HDR:
            begin
                if (hpos < AddrBytes)
                    hdr_next(cur_addr, total_left == 0);
                else if (total_left == 0)
                    done_op();
                else
                begin
                    spi(BYTE_FF, total_left == 1);
                    ph = PH_RD_DATA;
                end
            end
            PH_RD_DATA:
            begin
                put(KIND_READ, 8'd0, 1'b0, {8'd0, rx}, 13'd0);
                if (total_left > 0)
                    total_left--;
                if (total_left == 0)
                    done_op();
                else
                    spi(BYTE_FF, total_left == 1);
            end
            PH_W_HDR:
            begin
                if (hpos < AddrBytes)
                    hdr_next(sec_base(), 0);
                else
                begin
                    bidx = 0;
                    spi(BYTE_FF, 1'b0);
                    ph = PH_W_FILL;
                end
            end
            PH_W_FILL:
            begin
                if (bidx < SectorSize)
                begin
                    sec_copy[bidx] = rx;
                    if (bidx >= sec_off && bidx < sec_off + sec_left && rx != BYTE_FF)
                        need_erase = 1;
                end
                bidx++;
                if (bidx < SectorSize)
                    spi(BYTE_FF, bidx == SectorSize - 1);
                else
                begin
                    put(KIND_DREQ, 8'd0, 1'b0, 16'd0, 13'(sec_left));
                    bidx = 0;
                    ph = PH_W_DATA;
                end
            end
            PH_E_WREN:
            begin
                spi(OP_RDSR, 1'b0);
                ph = PH_E_P1A;
            end
            PH_E_P1A, PH_E_P2A, PH_P_PA:
            begin
                spi(BYTE_FF, 1'b1);
                ph = phase_t'(ph + 1);
            end
            PH_E_P1B:
            begin
                if (rx[0])
                begin
                    spi(OP_RDSR, 1'b0);
                    ph = PH_E_P1A;
                end
                else
                begin
                    spi(pend_op, pend_op == OP_CE);
                    hpos = (pend_op == OP_CE) ? AddrBytes : 0;
                    ph = PH_E_HDR;
                end
            end
            PH_E_HDR:
            begin
                if (hpos < AddrBytes)
                    hdr_next(sec_base(), 1);
                else
                begin
                    spi(OP_RDSR, 1'b0);
                    ph = PH_E_P2A;
                end
            end
            PH_E_P2B:
            begin
                if (rx[0])
                begin
                    spi(OP_RDSR, 1'b0);
                    ph = PH_E_P2A;
                end
                else if (need_erase)
                    start_program();
                else
                    done_op();
            end
            PH_P_WREN:
            begin
                spi(OP_PP, 1'b0);
                hpos = 0;
                ph = PH_P_HDR;
            end
            PH_P_HDR:
            begin
                hdr_next(24'(sec_base() + bidx), 0);
                if (hpos >= AddrBytes)
                    ph = PH_P_DATA;
            end
            PH_P_DATA:
            begin
                if (page_left == 0)
                begin
                    spi(OP_RDSR, 1'b0);
                    ph = PH_P_PA;
                end
                else
                begin
                    spi((bidx < SectorSize) ? sec_copy[bidx] : BYTE_FF, page_left == 1);
                    bidx++;
                    page_left--;
                end
            end
            PH_P_PB:
            begin
                if (rx[0])
                begin
                    spi(OP_RDSR, 1'b0);
                    ph = PH_P_PA;
                end
                else if (bidx < prog_end())
                    start_page();
                else
                begin
                    cur_addr = (cur_addr + sec_left) & AddrMask;
                    total_left = (total_left > sec_left) ? total_left - sec_left : 0;
                    if (total_left == 0)
                        done_op();
                    else
                        start_sector();
                end
            end
            default: put(KIND_ERR, 8'd0, 1'b0, 16'd0, 13'd0);
        endcase
    endfunction

    // works out the results of one accepted request and queues them
    function automatic void predict_flash(in_item_t it);
        int unsigned idx;
        step_results.delete();
        if (ph == PH_IDLE)
            host_cmd(it);
        else if (ph == PH_W_DATA)
        begin
            if (it.req_type != REQ_DATA)
                put(KIND_ERR, 8'd0, 1'b0, 16'd0, 13'd0);
            else
            begin
                idx = sec_off + bidx;
                if (idx < SectorSize)
                    sec_copy[idx] = it.data_byte;
                bidx++;
                if (bidx >= sec_left)
                begin
                    if (need_erase)
                        start_erase(OP_SE);
                    else
                        start_program();
                end
            end
        end
        else if (it.req_type != REQ_RX)
            put(KIND_ERR, 8'd0, 1'b0, 16'd0, 13'd0);
        else
            spi_return(it.data_byte);
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            owed_results.push_back(step_results[i]);
    endfunction

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with nothing expected, kind %0d", out_data.kind);
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (out_data.kind !== want.kind)
                begin
                    $error("kind expected %0d got %0d", want.kind, out_data.kind);
                    error_count++;
                end
                if (out_data.spi_byte !== want.spi_byte)
                begin
                    $error("spi_byte expected %h got %h", want.spi_byte, out_data.spi_byte);
                    error_count++;
                end
                if (out_data.release_select !== want.release_select)
                begin
                    $error("release_select expected %b got %b", want.release_select,
                           out_data.release_select);
                    error_count++;
                end
                if (out_data.value !== want.value)
                begin
                    $error("value expected %h got %h", want.value, out_data.value);
                    error_count++;
                end
                if (out_data.data_count !== want.data_count)
                begin
                    $error("data_count expected %0d got %0d", want.data_count,
                           out_data.data_count);
                    error_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last expected %b got %b", want.last, out_data.last);
                    error_count++;
                end
            end
        end
    end

    // ---------------- request side ----------------

    // drives one request until taken; valid stays high unless a gap follows
    task automatic send_request(in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_flash(it);
        if (!no_idling && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t make_item(logic [3:0] req, logic [23:0] a, logic [15:0] len,
                                           logic [7:0] db);
        in_item_t it;
        it.req_type = req;
        it.address = a;
        it.length = len;
        it.data_byte = db;
        return it;
    endfunction

    // the request the flash side or the host would give next in this phase
    function automatic in_item_t follow_item();
        logic [7:0] rx;
        logic [23:0] a;
        logic [15:0] len;
        a = 24'($urandom);
        len = 16'($urandom);
        rx = 8'($urandom);
        if (ph == PH_W_DATA)
            return make_item(REQ_DATA, a, len, rx);
        case (ph)
            PH_W_FILL: rx = (dirty_fill && $urandom_range(1)) ? rx : BYTE_FF;
            // busy bit set now and then so the polling loops turn round
            PH_E_P1B, PH_E_P2B, PH_P_PB: rx[0] = ($urandom_range(99) < 30);
            default: ;
        endcase
        return make_item(REQ_RX, a, len, rx);
    endfunction

    // a request other than the one the block waits for
    function automatic in_item_t wrong_item();
        logic [3:0] req;
        if (ph == PH_W_DATA)
            req = REQ_RX;
        else
        begin
            req = 4'($urandom_range(15));
            if (req == REQ_RX)
                req = REQ_DATA;
        end
        return make_item(req, 24'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    // issues a host command and answers it until the sequencer is idle
    task automatic run_command(in_item_t it, int noise_pct);
        send_request(it);
        while (ph != PH_IDLE)
        begin
            if ($urandom_range(99) < noise_pct)
                send_request(wrong_item());
            else
                send_request(follow_item());
        end
    endtask

    task automatic wait_drained();
        drop_valid();
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_idle_errors();
        send_request(make_item(REQ_DATA, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        send_request(make_item(REQ_RX, 24'd0, 16'd0, 8'd0));
        send_request(make_item(4'd13, 24'd0, 16'd0, 8'd0));
        send_request(make_item(4'd14, 24'd0, 16'd0, 8'd0));
        send_request(make_item(4'd15, 24'hFFFFFF, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_simple_commands();
        run_command(make_item(REQ_RDSR, 24'd0, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_WRSR, 24'd0, 16'd0, 8'h00), 0);
        run_command(make_item(REQ_WRSR, 24'd0, 16'd0, 8'hFF), 0);
        run_command(make_item(REQ_WREN, 24'd0, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_WRDI, 24'd0, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_ID, 24'd0, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_PD, 24'd0, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_WAKE, 24'd0, 16'd0, 8'd0), 0);
    endtask

    task automatic test_erase();
        // sector index wraps at the top of the address space
        run_command(make_item(REQ_ERASE, 24'hFFFFFF, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_CHIP, 24'd0, 16'd0, 8'd0), 0);
    endtask

    task automatic test_reads();
        // zero length still sends opcode and address
        run_command(make_item(REQ_READ, 24'd0, 16'd0, 8'd0), 0);
        run_command(make_item(REQ_READ, 24'hFFFFFF, 16'd1, 8'd0), 0);
        run_command(make_item(REQ_READ, 24'h123456, 16'd5, 8'd0), 0);
    endtask

    task automatic test_wrong_items();
        // wrong requests while busy give an error and leave the sequence alone
        run_command(make_item(REQ_READ, 24'h00ABCD, 16'd3, 8'd0), 30);
    endtask

    task automatic test_writes();
        // zero-length write finishes at once
        run_command(make_item(REQ_WRITE, 24'h000100, 16'd0, 8'd0), 0);
        // clean range, programme the range only
        dirty_fill = 0;
        run_command(make_item(REQ_WRITE, 24'h0000F8, 16'd20, 8'd0), 0);
        // dirty range over a sector boundary, erase and rewrite both sectors
        dirty_fill = 1;
        run_command(make_item(REQ_WRITE, 24'h001FF0, 16'd40, 8'd0), 0);
    endtask

    task automatic test_drain_pause();
        run_command(make_item(REQ_RDSR, 24'd0, 16'd0, 8'd0), 0);
        send_request(make_item(REQ_WREN, 24'd0, 16'd0, 8'd0));
        send_request(follow_item());
        wait_drained();
    endtask

    task automatic test_random();
        in_item_t it;
        int writes_left;
        writes_left = 2;
        for (int n = 0; n < 130; n++)
        begin
            // a stretch with no idling on either side
            no_idling = (n < 40);
            it = make_item(4'($urandom_range(15)), 24'($urandom), 16'($urandom),
                           8'($urandom));
            if (it.req_type == REQ_WRITE)
            begin
                if (writes_left == 0)
                    it.req_type = REQ_READ;
                else
                begin
                    writes_left--;
                    it.length = 16'($urandom_range(1, 48));
                    dirty_fill = $urandom_range(1);
                end
            end
            if (it.req_type == REQ_READ)
                it.length = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 300))
                                                     : 16'($urandom_range(0, 12));
            run_command(it, 4);
        end
        no_idling = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        ph = PH_IDLE;
        cur_addr = '0;
        total_left = 0;
        sec_off = 0;
        sec_left = 0;
        page_left = 0;
        bidx = 0;
        need_erase = 0;
        id_word = '0;
        hpos = 0;
        pend_op = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_errors();
        test_simple_commands();
        test_erase();
        test_reads();
        test_wrong_items();
        test_drain_pause();
        test_writes();
        test_random();

        wait_drained();
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
